// File: hdl/sbfa_pkg.sv
// Package for the segregated best-fit allocator.
// Holds table sizes, widths, status codes, register indexes, request types and a size-class function; no dependencies.
package sbfa_pkg;
  localparam int HEAP_WORDS = 1048576;
  localparam int MAX_FREE_BLOCKS = 64;
  localparam int MAX_USED_BLOCKS = 64;
  localparam int FIDX_W = $clog2(MAX_FREE_BLOCKS);
  localparam int UIDX_W = $clog2(MAX_USED_BLOCKS);
  localparam int LEN_W = 21;
  localparam int ADDR_W = 20;
  localparam int BYTES_W = 23;
  localparam int CFG_W = 21;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [1:0] REG_HEAP_WORDS = 2'd0;
  localparam logic [1:0] REG_SMALL_LIMIT = 2'd1;
  localparam logic [1:0] REG_MEDIUM_LIMIT = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  // Size class of a length under the current limits.
  function automatic logic [1:0] size_class(input logic [LEN_W-1:0] len,
                                            input logic [LEN_W-1:0] sl,
                                            input logic [LEN_W-1:0] ml);
    logic [1:0] c;
    begin
      if (len <= sl) c = 2'd0;
      else if (len <= ml) c = 2'd1;
      else c = 2'd2;
      return c;
    end
  endfunction
endpackage

// File: hdl/segregated_best_fit_allocator.sv
// Segregated best-fit allocator, one item at a time. After the input item is taken, an
// alloc scans the used table, then the free table once per size class searched (up to
// three), then updates; a free scans both tables, searches for a slot and updates.
// When m_tready is high the result is taken and the block returns to idle for the next item.
// Reset (rst, synchronous) restores the whole heap as one free block of HEAP_WORDS words,
// clears the granted table; valid bits change at once. Depends on sbfa_pkg.
module segregated_best_fit_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // alloc_bytes[22:0], free_addr[42:23], zero fill
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], block_addr[21:2], zero fill
);
  localparam int FW = sbfa_pkg::FIDX_W;
  localparam int UW = sbfa_pkg::UIDX_W;
  localparam int LW = sbfa_pkg::LEN_W;
  localparam int AW = sbfa_pkg::ADDR_W;
  localparam int NF = sbfa_pkg::MAX_FREE_BLOCKS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_USCAN = 3'd1;
  localparam logic [2:0] ST_FSCAN = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0] state;
  logic [LW-1:0] small_limit, medium_limit;

  logic [AW-1:0] free_start [sbfa_pkg::MAX_FREE_BLOCKS];
  logic [LW-1:0] free_length [sbfa_pkg::MAX_FREE_BLOCKS];
  logic [NF-1:0] free_valid;
  logic [NF-1:0] free_valid_next;
  logic [AW-1:0] used_start [sbfa_pkg::MAX_USED_BLOCKS];
  logic [LW-1:0] used_length [sbfa_pkg::MAX_USED_BLOCKS];
  logic [sbfa_pkg::MAX_USED_BLOCKS-1:0] used_valid;

  logic          req;
  logic [LW-1:0] need;       // words + 1 (alloc) or block length (free)
  logic [1:0]    cls;
  logic [AW-1:0] begin_a;
  logic [LW-1:0] end_a;
  logic [FW:0]   fi;
  logic [UW:0]   ui;
  logic [UW-1:0] u_idx;
  logic          best_ok, prev_ok, next_ok, slot_ok;
  logic [FW-1:0] best, prev_i, next_i, slot;
  logic [LW-1:0] best_len, prev_len, next_len;
  logic [AW-1:0] best_st, prev_st;
  logic [1:0]    status;
  logic [AW-1:0] out_addr;

  logic [22:0] in_bytes;
  logic [AW-1:0] in_faddr;
  logic [LW:0] in_words;
  logic too_big;
  assign in_bytes = s_tdata[22:0];
  assign in_faddr = s_tdata[42:23];
  assign in_words = (LW+1)'((24'(in_bytes) + 24'd3) >> 2);
  // A request above the heap size can never fit any block.
  assign too_big = in_words > (LW+1)'(sbfa_pkg::HEAP_WORDS);

  // Registered read ports: the data registers hold the entry under the scan pointer,
  // so the address presented is the pointer's next value.
  logic [FW-1:0] fp, f_ra;
  logic [UW-1:0] u_ra;
  logic [AW-1:0] e_st, u_st;
  logic [LW-1:0] e_len, u_len;
  logic          e_v;
  logic [LW-1:0] e_end;
  logic          fit_better;
  assign fp = fi[FW-1:0];
  assign f_ra = (state == ST_FSCAN) ? fp + FW'(1) : '0;
  assign u_ra = (state == ST_USCAN) ? ui[UW-1:0] + UW'(1) : '0;

  always_ff @(posedge clk) begin
    e_st <= free_start[f_ra];
    e_len <= free_length[f_ra];
    u_st <= used_start[u_ra];
    u_len <= used_length[u_ra];
  end

  // Shared compare unit on the entry under the scan pointer.
  assign e_v = free_valid[fp];
  assign e_end = LW'(e_st) + e_len;
  assign fit_better = e_v && sbfa_pkg::size_class(e_len, small_limit, medium_limit) == cls
                      && e_len >= need
                      && (!best_ok || e_len < best_len || (e_len == best_len && e_st < best_st));

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {2'b00, out_addr, status};

  logic [LW-1:0] hw_clamp;
  assign hw_clamp = (cfg_data > LW'(sbfa_pkg::HEAP_WORDS)) ? LW'(sbfa_pkg::HEAP_WORDS)
                                                           : cfg_data;
  logic [LW-1:0] rem;
  assign rem = best_len - need;
  logic [LW-1:0] merged;
  assign merged = need + (prev_ok ? prev_len : '0) + (next_ok ? next_len : '0);

  always_comb begin
    logic [NF-1:0] clr, set;
    clr = '0;
    set = '0;
    if (req == sbfa_pkg::REQ_ALLOC) begin
      if (best_ok && rem == '0) clr[best] = 1'b1;
    end else if (slot_ok) begin
      if (prev_ok) clr[prev_i] = 1'b1;
      if (next_ok) clr[next_i] = 1'b1;
      set[slot] = 1'b1;
    end
    free_valid_next = (free_valid & ~clr) | set;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      small_limit <= LW'(1024);
      medium_limit <= LW'(131072);
      free_valid <= NF'(1);
      free_start[0] <= '0;
      free_length[0] <= LW'(1048576);
      used_valid <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sbfa_pkg::REG_HEAP_WORDS: begin
            used_valid <= '0;
            free_valid <= NF'(hw_clamp != '0);
            free_start[0] <= '0;
            free_length[0] <= hw_clamp;
          end
          sbfa_pkg::REG_SMALL_LIMIT: small_limit <= cfg_data;
          sbfa_pkg::REG_MEDIUM_LIMIT: medium_limit <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: if (s_tvalid) begin
          req <= s_tuser;
          ui <= '0; fi <= '0;
          best_ok <= 1'b0; prev_ok <= 1'b0;
          next_ok <= 1'b0; slot_ok <= 1'b0;
          out_addr <= '0;
          need <= in_words[LW-1:0] + LW'(1);
          cls <= sbfa_pkg::size_class(in_words[LW-1:0], small_limit, medium_limit);
          begin_a <= in_faddr - AW'(1);
          if (s_tuser == sbfa_pkg::REQ_FREE && in_faddr == '0) begin
            status <= sbfa_pkg::STATUS_UNKNOWN;
            state <= ST_OUT;
          end else if (s_tuser == sbfa_pkg::REQ_ALLOC && too_big) begin
            status <= sbfa_pkg::STATUS_NOFIT;
            state <= ST_OUT;
          end else state <= ST_USCAN;
        end
        ST_USCAN: begin
          // Alloc looks for an empty used entry, free for the matching header.
          if (req == sbfa_pkg::REQ_ALLOC ? !used_valid[ui[UW-1:0]]
              : (used_valid[ui[UW-1:0]] && u_st == begin_a)) begin
            u_idx <= ui[UW-1:0];
            if (req == sbfa_pkg::REQ_FREE) begin
              need <= u_len;
              end_a <= LW'(begin_a) + u_len;
            end
            state <= ST_FSCAN;
          end else if (ui == (UW+1)'(sbfa_pkg::MAX_USED_BLOCKS - 1)) begin
            status <= (req == sbfa_pkg::REQ_ALLOC) ? sbfa_pkg::STATUS_NOFIT
                                                   : sbfa_pkg::STATUS_UNKNOWN;
            state <= ST_OUT;
          end
          ui <= ui + 1'b1;
        end
        ST_FSCAN: begin
          if (req == sbfa_pkg::REQ_ALLOC) begin
            if (fit_better) begin
              best_ok <= 1'b1; best <= fp; best_len <= e_len; best_st <= e_st;
            end
          end else if (e_v) begin
            if (!next_ok && LW'(e_st) == end_a) begin
              next_ok <= 1'b1; next_i <= fp; next_len <= e_len;
            end else if (!prev_ok && e_end == LW'(begin_a)) begin
              prev_ok <= 1'b1; prev_i <= fp; prev_st <= e_st; prev_len <= e_len;
            end
          end
          if (fi == (FW+1)'(sbfa_pkg::MAX_FREE_BLOCKS - 1)) begin
            fi <= '0;
            if (req == sbfa_pkg::REQ_ALLOC) begin
              if (best_ok || fit_better || cls == 2'd2) state <= ST_APPLY;
              else cls <= cls + 2'd1;
            end else state <= ST_EMPTY;
          end else fi <= fi + 1'b1;
        end
        ST_EMPTY: begin
          if (prev_ok) begin slot_ok <= 1'b1; slot <= prev_i; state <= ST_APPLY; end
          else if (next_ok) begin slot_ok <= 1'b1; slot <= next_i; state <= ST_APPLY; end
          else if (!e_v) begin slot_ok <= 1'b1; slot <= fp; state <= ST_APPLY; end
          else if (fi == (FW+1)'(sbfa_pkg::MAX_FREE_BLOCKS - 1)) state <= ST_APPLY;
          fi <= fi + 1'b1;
        end
        ST_APPLY: begin
          state <= ST_OUT;
          free_valid <= free_valid_next;
          if (req == sbfa_pkg::REQ_ALLOC) begin
            if (!best_ok) status <= sbfa_pkg::STATUS_NOFIT;
            else begin
              status <= sbfa_pkg::STATUS_OK;
              if (rem != '0) begin
                free_start[best] <= best_st + AW'(need);
                free_length[best] <= rem;
              end
              used_start[u_idx] <= best_st;
              used_length[u_idx] <= need;
              used_valid[u_idx] <= 1'b1;
              out_addr <= best_st + AW'(1);
            end
          end else if (!slot_ok) status <= sbfa_pkg::STATUS_NOFIT;
          else begin
            status <= sbfa_pkg::STATUS_OK;
            free_start[slot] <= prev_ok ? prev_st : begin_a;
            free_length[slot] <= merged;
            used_valid[u_idx] <= 1'b0;
          end
        end
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_nohs: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while result pending");
  a_ok_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != sbfa_pkg::STATUS_OK |-> out_addr == '0)
    else $error("failed request with nonzero address");
  a_free_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && req == sbfa_pkg::REQ_FREE |-> out_addr == '0)
    else $error("free request with nonzero address");
`endif
endmodule

// File: bench/sbfa_checker.sv
// Checker for the segregated best-fit allocator: watches both streams,
// keeps its own copy of the free and granted tables and compares each result.
// Depends on sbfa_pkg.
module sbfa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  localparam int LEN_W = sbfa_pkg::LEN_W;
  localparam int ADDR_W = sbfa_pkg::ADDR_W;
  localparam int BYTES_W = sbfa_pkg::BYTES_W;
  localparam int HEAP_WORDS = sbfa_pkg::HEAP_WORDS;
  localparam int MAX_FREE_BLOCKS = sbfa_pkg::MAX_FREE_BLOCKS;
  localparam int MAX_USED_BLOCKS = sbfa_pkg::MAX_USED_BLOCKS;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } grant_t;

  logic [LEN_W-1:0]  heap_sz, lim_s, lim_m;
  logic [ADDR_W-1:0] fr_start [MAX_FREE_BLOCKS];
  logic [LEN_W-1:0]  fr_len   [MAX_FREE_BLOCKS];
  logic              fr_ok    [MAX_FREE_BLOCKS];
  logic [ADDR_W-1:0] us_start [MAX_USED_BLOCKS];
  logic [LEN_W-1:0]  us_len   [MAX_USED_BLOCKS];
  logic              us_ok    [MAX_USED_BLOCKS];
  grant_t            grants_due[$];

  function automatic logic [1:0] cls(logic [LEN_W:0] len);
    if (len <= {1'b0, lim_s}) return 2'd0;
    if (len <= {1'b0, lim_m}) return 2'd1;
    return 2'd2;
  endfunction

  task automatic clear_heap();
    for (int i = 0; i < MAX_FREE_BLOCKS; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_ok[i] = 1'b0;
    end
    for (int i = 0; i < MAX_USED_BLOCKS; i++) us_ok[i] = 1'b0;
    if (heap_sz != 0) begin
      fr_len[0] = heap_sz; fr_ok[0] = 1'b1;
    end
  endtask

  task automatic size_heap(logic [20:0] v);
    heap_sz = (v > HEAP_WORDS) ? LEN_W'(HEAP_WORDS) : v;
    clear_heap();
  endtask

  task automatic grant(logic [BYTES_W-1:0] bytes, output grant_t g);
    int u, best;
    logic [LEN_W:0] words, need;
    logic [LEN_W-1:0] rem;
    logic [ADDR_W-1:0] s;
    u = -1; best = -1;
    g = '{status: sbfa_pkg::STATUS_NOFIT, addr: '0};
    for (int i = 0; i < MAX_USED_BLOCKS; i++)
      if (!us_ok[i] && u < 0) u = i;
    if (u < 0) return;
    words = (LEN_W+1)'((24'(bytes) + 24'd3) >> 2);
    need = words + 1'b1;
    for (int c = cls(words); c <= 2 && best < 0; c++)
      for (int i = 0; i < MAX_FREE_BLOCKS; i++) begin
        if (!fr_ok[i] || cls({1'b0, fr_len[i]}) != c || {1'b0, fr_len[i]} < need) continue;
        if (best < 0 || fr_len[i] < fr_len[best] ||
            (fr_len[i] == fr_len[best] && fr_start[i] < fr_start[best]))
          best = i;
      end
    if (best < 0) return;
    s = fr_start[best];
    rem = fr_len[best] - LEN_W'(need);
    if (rem > 0) begin
      fr_start[best] = s + ADDR_W'(need);
      fr_len[best] = rem;
    end else begin
      fr_ok[best] = 1'b0;
    end
    us_start[u] = s; us_len[u] = LEN_W'(need); us_ok[u] = 1'b1;
    g = '{status: sbfa_pkg::STATUS_OK, addr: s + 1'b1};
  endtask

  task automatic release_block(logic [ADDR_W-1:0] a, output grant_t g);
    int u, prv, nxt, slot;
    logic [ADDR_W-1:0] begin_w, nstart;
    logic [LEN_W-1:0] len, nlen;
    logic [LEN_W:0] end_w;
    u = -1; prv = -1; nxt = -1; slot = -1;
    g = '{status: sbfa_pkg::STATUS_UNKNOWN, addr: '0};
    if (a == 0) return;
    begin_w = a - 1'b1;
    for (int i = 0; i < MAX_USED_BLOCKS; i++)
      if (u < 0 && us_ok[i] && us_start[i] == begin_w) u = i;
    if (u < 0) return;
    len = us_len[u];
    end_w = (LEN_W+1)'(begin_w) + len;
    for (int i = 0; i < MAX_FREE_BLOCKS; i++) begin
      if (!fr_ok[i]) continue;
      if (nxt < 0 && (LEN_W+1)'(fr_start[i]) == end_w) nxt = i;
      else if (prv < 0 && (LEN_W+1)'(fr_start[i]) + fr_len[i] == (LEN_W+1)'(begin_w))
        prv = i;
    end
    if (prv >= 0) slot = prv;
    else if (nxt >= 0) slot = nxt;
    else
      for (int i = 0; i < MAX_FREE_BLOCKS; i++)
        if (slot < 0 && !fr_ok[i]) slot = i;
    if (slot < 0) begin
      g.status = sbfa_pkg::STATUS_NOFIT;
      return;
    end
    nstart = begin_w; nlen = len;
    if (prv >= 0) begin
      nstart = fr_start[prv]; nlen += fr_len[prv]; fr_ok[prv] = 1'b0;
    end
    if (nxt >= 0) begin
      nlen += fr_len[nxt]; fr_ok[nxt] = 1'b0;
    end
    fr_start[slot] = nstart; fr_len[slot] = nlen; fr_ok[slot] = 1'b1;
    us_ok[u] = 1'b0;
    g.status = sbfa_pkg::STATUS_OK;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      fail_count = 0;
      lim_s = 21'd1024; lim_m = 21'd131072;
      size_heap(21'd1048576);
      grants_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (grants_due.size() == 0) begin
          report("unexpected result, status", 32'(m_tdata[1:0]), 32'd0);
        end else begin
          g = grants_due.pop_front();
          if (m_tdata[1:0] != g.status)
            report("status", 32'(m_tdata[1:0]), 32'(g.status));
          if (m_tdata[21:2] != g.addr)
            report("block_addr", 32'(m_tdata[21:2]), 32'(g.addr));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == sbfa_pkg::REQ_ALLOC) grant(s_tdata[22:0], g);
        else release_block(s_tdata[42:23], g);
        grants_due.insert(grants_due.size(), g);
      end
      if (cfg_we) begin
        case (cfg_index)
          sbfa_pkg::REG_HEAP_WORDS:   size_heap(cfg_data);
          sbfa_pkg::REG_SMALL_LIMIT:  lim_s = cfg_data;
          sbfa_pkg::REG_MEDIUM_LIMIT: lim_m = cfg_data;
          default: ;
        endcase
      end
    end
    pending = grants_due.size();
  end
endmodule

// File: bench/tb_segregated_best_fit_allocator.sv
// Top of the allocator regression: drives requests and register writes,
// applies random stalls and gives the verdict. Depends on sbfa_pkg, sbfa_checker, segregated_best_fit_allocator.
module tb_segregated_best_fit_allocator;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [20:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // alloc_bytes[22:0], free_addr[42:23], zero fill
  logic        s_tuser = 1'b0; // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // status[1:0], block_addr[21:2], zero fill
  int          fail_count, pending;
  int          cycles = 0;
  bit          steady = 1'b0;
  logic [sbfa_pkg::ADDR_W-1:0] live_addrs[$];

  always #10 clk = ~clk;

  segregated_best_fit_allocator uut (.*);

  sbfa_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
    if (cycles > CYCLE_LIMIT) begin
      $display("segregated_best_fit_allocator regression: fail");
      $finish;
    end
  end

  // Grants are learned from the result stream so frees can name live blocks.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready && m_tdata[1:0] == sbfa_pkg::STATUS_OK
        && m_tdata[21:2] != 0)
      live_addrs.insert(live_addrs.size(), m_tdata[21:2]);

  task automatic send(logic kind, logic [22:0] bytes, logic [19:0] addr);
    if (!steady)
      while ($urandom_range(99) < 24) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'd0, addr, bytes};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (220) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sbfa_pkg::REG_HEAP_WORDS) live_addrs.delete();
    @(posedge clk);
  endtask

  task automatic free_one();
    int k;
    logic [19:0] a;
    if (live_addrs.size() == 0 || $urandom_range(9) == 0) begin
      a = 20'($urandom);
    end else begin
      k = int'($urandom_range(live_addrs.size() - 1));
      a = live_addrs[k];
      // Keep some addresses around so double frees happen too.
      if ($urandom_range(7) != 0) live_addrs.delete(k);
    end
    send(sbfa_pkg::REQ_FREE, 23'($urandom), a);
  endtask

  task automatic random_phase(int n, int max_bytes);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 52)
        send(sbfa_pkg::REQ_ALLOC, 23'($urandom_range(max_bytes)), 20'($urandom));
      else
        free_one();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part: extremes, exact fit, zero bytes, bad frees, fallbacks.
    send(sbfa_pkg::REQ_ALLOC, 23'd0, 20'hFFFFF);
    send(sbfa_pkg::REQ_ALLOC, 23'd4194304, 20'd0);
    send(sbfa_pkg::REQ_ALLOC, 23'h7FFFFF, 20'd0);
    send(sbfa_pkg::REQ_FREE, 23'h7FFFFF, 20'd0);
    send(sbfa_pkg::REQ_FREE, 23'd0, 20'd1);
    send(sbfa_pkg::REQ_FREE, 23'd0, 20'd1);
    send(sbfa_pkg::REQ_FREE, 23'd0, 20'hFFFFF);
    drain();
    write_reg(sbfa_pkg::REG_HEAP_WORDS, 21'd40);
    write_reg(sbfa_pkg::REG_SMALL_LIMIT, 21'd4);
    write_reg(sbfa_pkg::REG_MEDIUM_LIMIT, 21'd12);
    send(sbfa_pkg::REQ_ALLOC, 23'd12, 20'd0);
    send(sbfa_pkg::REQ_ALLOC, 23'd40, 20'd0);
    send(sbfa_pkg::REQ_ALLOC, 23'd1, 20'd0);
    send(sbfa_pkg::REQ_ALLOC, 23'd80, 20'd0);
    send(sbfa_pkg::REQ_FREE, 23'd0, 20'd1);
    send(sbfa_pkg::REQ_FREE, 23'd0, 20'd16);
    send(sbfa_pkg::REQ_FREE, 23'd0, 20'd5);
    send(sbfa_pkg::REQ_ALLOC, 23'd152, 20'd0);
    send(sbfa_pkg::REQ_ALLOC, 23'd160, 20'd0);
    drain();
    write_reg(sbfa_pkg::REG_HEAP_WORDS, 21'd0);
    send(sbfa_pkg::REQ_ALLOC, 23'd0, 20'd0);
    drain();
    write_reg(sbfa_pkg::REG_HEAP_WORDS, 21'h1FFFFF);
    write_reg(sbfa_pkg::REG_SMALL_LIMIT, 21'h1FFFFF);
    write_reg(sbfa_pkg::REG_MEDIUM_LIMIT, 21'h1FFFFF);
    send(sbfa_pkg::REQ_ALLOC, 23'd4194300, 20'd0);
    send(sbfa_pkg::REQ_ALLOC, 23'd0, 20'd0);
    drain();
    live_addrs.delete();
    // Random phases over several limit settings.
    write_reg(sbfa_pkg::REG_HEAP_WORDS, 21'd300);
    write_reg(sbfa_pkg::REG_SMALL_LIMIT, 21'd4);
    write_reg(sbfa_pkg::REG_MEDIUM_LIMIT, 21'd16);
    random_phase(450, 100);
    drain();
    write_reg(sbfa_pkg::REG_SMALL_LIMIT, 21'd1);
    write_reg(sbfa_pkg::REG_MEDIUM_LIMIT, 21'd1);
    steady = 1'b1;
    random_phase(250, 60);
    drain();
    steady = 1'b0;
    write_reg(sbfa_pkg::REG_HEAP_WORDS, 21'd1048576);
    write_reg(sbfa_pkg::REG_SMALL_LIMIT, 21'd1024);
    write_reg(sbfa_pkg::REG_MEDIUM_LIMIT, 21'd131072);
    random_phase(450, 4194304);
    drain();
    // A small heap with tiny requests fills the used table.
    write_reg(sbfa_pkg::REG_HEAP_WORDS, 21'd1000);
    write_reg(sbfa_pkg::REG_SMALL_LIMIT, 21'd2);
    write_reg(sbfa_pkg::REG_MEDIUM_LIMIT, 21'd8);
    for (int i = 0; i < 70; i++)
      send(sbfa_pkg::REQ_ALLOC, 23'($urandom_range(8)), 20'd0);
    random_phase(630, 40);
    drain();
    if (fail_count == 0) begin
      $display("segregated_best_fit_allocator regression: pass");
    end else begin
      $display("segregated_best_fit_allocator regression: fail");
    end
    $finish;
  end
endmodule

// File: segregated_best_fit_allocator.f
hdl/sbfa_pkg.sv
hdl/segregated_best_fit_allocator.sv
bench/sbfa_checker.sv
bench/tb_segregated_best_fit_allocator.sv
